FILE: rtl/core/fccm_pkg.sv
// Shared types, codes and constants of the cluster chain manager.
// Used by the controller, datapath, top level and port checker; no dependencies.
package fccm_pkg;

	localparam int LINK_W     = 28;
	localparam int STEPS_W    = 11;
	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 28;

	localparam int TABLE_DEPTH_DEF = 1024;

	localparam logic [LINK_W-1:0]  EOC_VALUE         = 28'h0FFFFFFF;
	localparam logic [LINK_W-1:0]  FIRST_DATA        = 28'd2;
	localparam logic [STEPS_W-1:0] CLUSTER_COUNT_RST = 11'd1024;
	localparam logic [LINK_W-1:0]  END_MARKER_RST    = 28'h0FFFFFF8;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE    = 3'd0,
		MODE_READ     = 3'd1,
		MODE_SEEK     = 3'd2,
		MODE_SEEK_EXT = 3'd3,
		MODE_APPEND   = 3'd4,
		MODE_FREE     = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_FREE    = 3'd1,
		ST_CHAIN_END  = 3'd2,
		ST_BAD_INDEX  = 3'd3,
		ST_WALK_LIMIT = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLUSTER_COUNT = 1'b0,
		CFG_END_MARKER    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [LINK_W-1:0]  cluster;
		logic [LINK_W-1:0]  value;
		logic [STEPS_W-1:0] steps;
	} req_t;

	typedef struct packed {
		logic [LINK_W-1:0]   result_cluster;
		logic [STEPS_W-1:0]  links_done;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// result source selects
	typedef enum logic [2:0] {
		RES_ZERO = 3'd0,
		RES_VAL  = 3'd1,
		RES_RD   = 3'd2,
		RES_CUR  = 3'd3,
		RES_FREE = 3'd4
	} res_sel_t;

	typedef enum logic [1:0] {
		LNK_ZERO  = 2'd0,
		LNK_COUNT = 2'd1,
		LNK_ONE   = 2'd2
	} lnk_sel_t;

	// table write kinds
	typedef enum logic [2:0] {
		WR_NONE     = 3'd0,
		WR_VAL_CUR  = 3'd1,
		WR_LINK_CUR = 3'd2,
		WR_EOC_FREE = 3'd3,
		WR_ZERO_CUR = 3'd4,
		WR_ZERO_CLR = 3'd5
	} wr_sel_t;

	typedef struct packed {
		logic     load;
		logic     finish;
		res_sel_t res_sel;
		lnk_sel_t lnk_sel;
		status_t  status;
		logic     rd_cur;
		wr_sel_t  wr_sel;
		logic     cur_from_rd;
		logic     cur_from_free;
		logic     links_inc;
		logic     scan_start;
		logic     scan_step;
		logic     clear_step;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic cur_zero;
		logic cur_ge_end;
		logic cur_ge_lim;
		logic nxt_ge_end;
		logic links_eq_steps;
		logic steps_zero;
		logic links_zero;
		logic scan_found;
		logic scan_none;
		logic clear_last;
	} dp_stat_t;

endpackage

FILE: rtl/core/fccm_datapath.sv
// Datapath of the cluster chain manager: link table memory, config registers,
// walk and free-search registers, result register. Depends on fccm_pkg.
module fccm_datapath #(
	parameter int TABLE_DEPTH = fccm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fccm_pkg::req_t                  req,
	input  fccm_pkg::dp_cmd_t               cmd,
	output fccm_pkg::dp_stat_t              stat,
	input  logic                            cfg_we,
	input  logic [fccm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fccm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                            done,
	output fccm_pkg::rsp_t                  rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;
	localparam int LW = fccm_pkg::LINK_W;
	localparam int SW = fccm_pkg::STEPS_W;

	logic [SW-1:0]     cluster_count_q;
	logic [LW-1:0]     end_marker_q;
	logic [fccm_pkg::MODE_W-1:0] mode_q;
	logic [LW-1:0]     cur_q;
	logic [LW-1:0]     val_q;
	logic [SW-1:0]     steps_q;
	logic [SW-1:0]     links_q;
	logic [AW-1:0]     free_q;
	logic [CW-1:0]     scan_q;
	logic              pend_q;
	logic [AW-1:0]     pend_addr_s1;
	logic [LW-1:0]     rd_q;
	logic              done_q;
	fccm_pkg::rsp_t    rsp_q;
	logic [LW-1:0]     table_q [TABLE_DEPTH];

	logic [LW-1:0]     lim;
	logic              scan_lt_lim;
	logic              scan_found;
	logic              scan_issue;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [LW-1:0]     wr_data;
	logic [LW-1:0]     res_val;
	logic [SW-1:0]     lnk_val;

	// effective limit: cluster count capped at the table depth
	always_comb begin
		if (LW'(cluster_count_q) < LW'(TABLE_DEPTH)) begin
			lim = LW'(cluster_count_q);
		end else begin
			lim = LW'(TABLE_DEPTH);
		end
	end

	assign scan_lt_lim = LW'(scan_q) < lim;
	assign scan_found  = pend_q && (rd_q == '0);
	assign scan_issue  = cmd.scan_step && !scan_found && scan_lt_lim;

	// status towards the controller
	always_comb begin
		stat.mode           = mode_q;
		stat.cur_zero       = cur_q == '0;
		stat.cur_ge_end     = cur_q >= end_marker_q;
		stat.cur_ge_lim     = cur_q >= lim;
		stat.nxt_ge_end     = rd_q >= end_marker_q;
		stat.links_eq_steps = links_q == steps_q;
		stat.steps_zero     = steps_q == '0;
		stat.links_zero     = links_q == '0;
		stat.scan_found     = scan_found;
		stat.scan_none      = !scan_lt_lim && !scan_found;
		stat.clear_last     = scan_q == CW'(TABLE_DEPTH - 1);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= fccm_pkg::CLUSTER_COUNT_RST;
			end_marker_q    <= fccm_pkg::END_MARKER_RST;
		end else if (cfg_we) begin
			if (cfg_idx == fccm_pkg::CFG_CLUSTER_COUNT) begin
				cluster_count_q <= cfg_wdata[SW-1:0];
			end else begin
				end_marker_q <= cfg_wdata[LW-1:0];
			end
		end
	end

	// item registers: load on accept, advance along the chain
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= req.mode;
			cur_q   <= req.cluster;
			val_q   <= req.value;
			steps_q <= req.steps;
			links_q <= '0;
		end else begin
			if (cmd.cur_from_rd) begin
				cur_q <= rd_q;
			end else if (cmd.cur_from_free) begin
				cur_q <= LW'(free_q);
			end
			if (cmd.links_inc) begin
				links_q <= links_q + SW'(1);
			end
		end
	end

	// free search and clearing sweep share the index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			pend_q <= 1'b0;
		end else if (cmd.clear_step) begin
			scan_q <= scan_q + CW'(1);
		end else if (cmd.scan_start) begin
			scan_q <= CW'(fccm_pkg::FIRST_DATA);
			pend_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (scan_issue) begin
				scan_q <= scan_q + CW'(1);
				pend_q <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			pend_addr_s1 <= scan_q[AW-1:0];
		end
		if (cmd.scan_step && scan_found) begin
			free_q <= pend_addr_s1;
		end
	end

	// table port selection
	assign rd_en   = cmd.rd_cur || scan_issue;
	assign rd_addr = cmd.rd_cur ? cur_q[AW-1:0] : scan_q[AW-1:0];

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = cur_q[AW-1:0];
		wr_data = '0;
		case (cmd.wr_sel)
			fccm_pkg::WR_VAL_CUR: begin
				wr_data = val_q;
			end
			fccm_pkg::WR_LINK_CUR: begin
				wr_data = LW'(free_q);
			end
			fccm_pkg::WR_EOC_FREE: begin
				wr_addr = free_q;
				wr_data = fccm_pkg::EOC_VALUE;
			end
			fccm_pkg::WR_ZERO_CUR: begin
				wr_data = '0;
			end
			fccm_pkg::WR_ZERO_CLR: begin
				wr_addr = scan_q[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// link table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= table_q[rd_addr];
		end
	end

	// result beat
	always_comb begin
		case (cmd.res_sel)
			fccm_pkg::RES_VAL:  res_val = val_q;
			fccm_pkg::RES_RD:   res_val = rd_q;
			fccm_pkg::RES_CUR:  res_val = cur_q;
			fccm_pkg::RES_FREE: res_val = LW'(free_q);
			default:            res_val = '0;
		endcase
		case (cmd.lnk_sel)
			fccm_pkg::LNK_COUNT: lnk_val = links_q;
			fccm_pkg::LNK_ONE:   lnk_val = SW'(1);
			default:             lnk_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.result_cluster <= res_val;
			rsp_q.links_done     <= lnk_val;
			rsp_q.status         <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/core/fccm_ctrl.sv
// Controller of the cluster chain manager: sequencer for clearing, walks,
// free search, allocation and chain release. Depends on fccm_pkg.
module fccm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fccm_pkg::dp_stat_t  stat,
	output fccm_pkg::dp_cmd_t   cmd
);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b000_0000_0001,
		S_CLEAR     = 11'b000_0000_0010,
		S_DISPATCH  = 11'b000_0000_0100,
		S_READ      = 11'b000_0000_1000,
		S_WALK      = 11'b000_0001_0000,
		S_WALK_RD   = 11'b000_0010_0000,
		S_SCAN      = 11'b000_0100_0000,
		S_ALLOC     = 11'b000_1000_0000,
		S_ALLOC_EOC = 11'b001_0000_0000,
		S_FREE_CHK  = 11'b010_0000_0000,
		S_FREE_RD   = 11'b100_0000_0000
	} state_t;

	// why a free search was started
	typedef enum logic [1:0] {
		PUR_HEAD   = 2'd0,
		PUR_EXTEND = 2'd1,
		PUR_APPEND = 2'd2
	} purpose_t;

	state_t   state_q, state_d;
	purpose_t purpose_q, purpose_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			purpose_q <= PUR_HEAD;
		end else begin
			state_q   <= state_d;
			purpose_q <= purpose_d;
		end
	end

	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d   = state_q;
		purpose_d = purpose_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			// sweep zeros through the table after reset
			S_CLEAR: begin
				cmd.wr_sel     = fccm_pkg::WR_ZERO_CLR;
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_DISPATCH: begin
				case (stat.mode)
					fccm_pkg::MODE_WRITE: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.cur_ge_lim) begin
							cmd.status = fccm_pkg::ST_BAD_INDEX;
						end else begin
							cmd.wr_sel  = fccm_pkg::WR_VAL_CUR;
							cmd.res_sel = fccm_pkg::RES_VAL;
						end
					end
					fccm_pkg::MODE_READ: begin
						if (stat.cur_ge_lim) begin
							cmd.finish = 1'b1;
							cmd.status = fccm_pkg::ST_BAD_INDEX;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_cur = 1'b1;
							state_d    = S_READ;
						end
					end
					fccm_pkg::MODE_SEEK: begin
						state_d = S_WALK;
					end
					fccm_pkg::MODE_SEEK_EXT: begin
						if (stat.cur_zero) begin
							purpose_d      = PUR_HEAD;
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end else begin
							state_d = S_WALK;
						end
					end
					fccm_pkg::MODE_APPEND: begin
						if (!stat.cur_zero && stat.cur_ge_lim) begin
							cmd.finish = 1'b1;
							cmd.status = fccm_pkg::ST_BAD_INDEX;
							state_d    = S_IDLE;
						end else begin
							purpose_d      = PUR_APPEND;
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					fccm_pkg::MODE_FREE: begin
						state_d = S_FREE_CHK;
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_READ: begin
				cmd.finish  = 1'b1;
				cmd.res_sel = fccm_pkg::RES_RD;
				state_d     = S_IDLE;
			end
			// loop head of both seek modes
			S_WALK: begin
				cmd.res_sel = fccm_pkg::RES_CUR;
				cmd.lnk_sel = fccm_pkg::LNK_COUNT;
				if (stat.links_eq_steps) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
					if (stat.steps_zero && !stat.cur_ge_end && stat.cur_ge_lim) begin
						cmd.status = fccm_pkg::ST_BAD_INDEX;
					end
				end else if (stat.cur_ge_end) begin
					cmd.finish = 1'b1;
					cmd.status = fccm_pkg::ST_CHAIN_END;
					state_d    = S_IDLE;
				end else if (stat.cur_ge_lim) begin
					cmd.finish = 1'b1;
					cmd.status = stat.links_zero ? fccm_pkg::ST_BAD_INDEX
					                             : fccm_pkg::ST_WALK_LIMIT;
					state_d    = S_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				if (stat.mode == fccm_pkg::MODE_SEEK_EXT && stat.nxt_ge_end) begin
					purpose_d      = PUR_EXTEND;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.cur_from_rd = 1'b1;
					cmd.links_inc   = 1'b1;
					state_d         = S_WALK;
				end
			end
			// lowest zero entry from index 2 upward
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_found) begin
					state_d = S_ALLOC;
				end else if (stat.scan_none) begin
					cmd.finish = 1'b1;
					cmd.status = fccm_pkg::ST_NO_FREE;
					state_d    = S_IDLE;
					if (purpose_q == PUR_EXTEND) begin
						cmd.res_sel = fccm_pkg::RES_CUR;
						cmd.lnk_sel = fccm_pkg::LNK_COUNT;
					end
				end
			end
			// link the tail first, if there is one, then mark the new cluster as chain end
			S_ALLOC: begin
				if (purpose_q == PUR_EXTEND || (purpose_q == PUR_APPEND && !stat.cur_zero)) begin
					cmd.wr_sel = fccm_pkg::WR_LINK_CUR;
				end
				state_d = S_ALLOC_EOC;
			end
			S_ALLOC_EOC: begin
				cmd.wr_sel = fccm_pkg::WR_EOC_FREE;
				case (purpose_q)
					PUR_APPEND: begin
						cmd.finish  = 1'b1;
						cmd.res_sel = fccm_pkg::RES_FREE;
						cmd.lnk_sel = fccm_pkg::LNK_ONE;
						state_d     = S_IDLE;
					end
					PUR_EXTEND: begin
						cmd.cur_from_free = 1'b1;
						cmd.links_inc     = 1'b1;
						state_d           = S_WALK;
					end
					default: begin
						cmd.cur_from_free = 1'b1;
						state_d           = S_WALK;
					end
				endcase
			end
			S_FREE_CHK: begin
				cmd.res_sel = fccm_pkg::RES_CUR;
				cmd.lnk_sel = fccm_pkg::LNK_COUNT;
				if (stat.cur_zero || stat.cur_ge_end) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else if (stat.cur_ge_lim) begin
					cmd.finish = 1'b1;
					cmd.status = stat.links_zero ? fccm_pkg::ST_BAD_INDEX
					                             : fccm_pkg::ST_WALK_LIMIT;
					state_d    = S_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_FREE_RD;
				end
			end
			// drop the entry and advance along the chain
			S_FREE_RD: begin
				cmd.wr_sel      = fccm_pkg::WR_ZERO_CUR;
				cmd.cur_from_rd = 1'b1;
				cmd.links_inc   = 1'b1;
				state_d         = S_FREE_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/fat_cluster_chain_manager.sv
// Top level of the cluster chain manager: controller plus datapath.
// Depends on fccm_pkg, fccm_ctrl and fccm_datapath.
//
// Usage: present an operation on req and raise start; it is taken at a clock
// edge where start is high and busy is low. Exactly one result beat follows on
// rsp, marked by done for a single cycle; the receiver cannot stall it and
// must take it in that cycle. Configuration is written through cfg_we,
// cfg_idx and cfg_wdata only while busy is low and no result is pending.
// Each operation is paced by the sequencer and the single read port of the
// link table (one table access per cycle, registered read data): a seek and
// a chain free read the table once per link followed or entry freed; each
// free-cluster search reads one entry a cycle from the first data cluster up
// to the limit; append runs one search, then links the tail if there is one
// and marks the new cluster as chain end; seek extend adds one search and one
// allocation for every cluster it allocates.
// One item is in work at a time; a new item may be taken in the cycle its
// result is shown. After reset busy stays high while the table is swept to zero;
// configuration writes are taken meanwhile.
module fat_cluster_chain_manager #(
	parameter int TABLE_DEPTH = fccm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  fccm_pkg::req_t                  req,
	output logic                            done,
	output fccm_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [fccm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fccm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	fccm_pkg::dp_cmd_t  cmd;
	fccm_pkg::dp_stat_t stat;

	fccm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	fccm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/core/fccm_checker.sv
// Port checker for the cluster chain manager, bound to the top level.
// Depends on fccm_pkg and fat_cluster_chain_manager.
module fccm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input fccm_pkg::req_t req,
	input logic           done,
	input fccm_pkg::rsp_t rsp
);

	// a result beat is shown only once the block is free again
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// no result beat in the cycle right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result beat too early after accept");

	// unused modes give an all-zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.mode > fccm_pkg::MODE_FREE)) |-> ##2 (done && (rsp == '0)))
		else $error("unused mode result wrong");

	// a bad index is only reported before any link is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == fccm_pkg::ST_BAD_INDEX)) |-> (rsp.links_done == '0))
		else $error("bad index with links taken");

endmodule

bind fat_cluster_chain_manager fccm_checker u_fccm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

FILE: test/fat_cluster_chain_manager_tb.sv
// Self-checking testbench for the cluster chain manager: directed and random operations
// against a local prediction of the link table, under several register settings.
// Depends on fccm_pkg and fat_cluster_chain_manager.
module fat_cluster_chain_manager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fccm_pkg::*;

	// mode codes the block treats as no-ops
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
	localparam int QUIET_LIMIT = 100000;

	// Prediction of the link table, the registers and the results still owed.
	class link_table_tracker;
		logic [LINK_W-1:0]  links[TABLE_DEPTH_DEF];
		logic [STEPS_W-1:0] count_reg;
		logic [LINK_W-1:0]  eoc_mark;
		rsp_t               awaited_q[$];
		int                 errors;

		function new();
			foreach (links[i]) links[i] = '0;
			count_reg = CLUSTER_COUNT_RST;
			eoc_mark  = END_MARKER_RST;
			errors    = 0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_CLUSTER_COUNT) begin
				count_reg = data[STEPS_W-1:0];
			end else begin
				eoc_mark = data[LINK_W-1:0];
			end
		endfunction

		function int unsigned index_limit();
			return (count_reg < TABLE_DEPTH_DEF) ? count_reg : TABLE_DEPTH_DEF;
		endfunction

		// lowest zero entry from the first data cluster up, 0 when none
		function int unsigned first_free();
			int unsigned lim;
			lim = index_limit();
			for (int unsigned i = FIRST_DATA; i < lim; i++) begin
				if (links[i] == '0) return i;
			end
			return 0;
		endfunction

		function rsp_t pack_result(int unsigned res, int unsigned n, status_t st);
			rsp_t p;
			p.result_cluster = res[LINK_W-1:0];
			p.links_done     = n[STEPS_W-1:0];
			p.status         = st;
			return p;
		endfunction

		// Apply one operation to the table and give the result it produces.
		function rsp_t run_operation(req_t r);
			int unsigned lim, cur, nxt, fr, hops;
			lim  = index_limit();
			cur  = r.cluster;
			hops = 0;
			case (r.mode)
				MODE_WRITE: begin
					if (cur >= lim) return pack_result(0, 0, ST_BAD_INDEX);
					links[cur] = r.value;
					return pack_result(r.value, 0, ST_OK);
				end
				MODE_READ: begin
					if (cur >= lim) return pack_result(0, 0, ST_BAD_INDEX);
					return pack_result(links[cur], 0, ST_OK);
				end
				MODE_SEEK, MODE_SEEK_EXT: begin
					// a zero start on extend opens a new chain first
					if (r.mode == MODE_SEEK_EXT && cur == 0) begin
						fr = first_free();
						if (fr == 0) return pack_result(0, 0, ST_NO_FREE);
						links[fr] = EOC_VALUE;
						cur = fr;
					end
					if (r.steps == 0) begin
						if (cur < eoc_mark && cur >= lim) return pack_result(cur, 0, ST_BAD_INDEX);
						return pack_result(cur, 0, ST_OK);
					end
					for (int unsigned i = 0; i < r.steps; i++) begin
						if (cur >= eoc_mark) return pack_result(cur, hops, ST_CHAIN_END);
						if (cur >= lim)
							return pack_result(cur, hops, (i == 0) ? ST_BAD_INDEX : ST_WALK_LIMIT);
						nxt = links[cur];
						// grow the chain instead of stopping at its end
						if (r.mode == MODE_SEEK_EXT && nxt >= eoc_mark) begin
							fr = first_free();
							if (fr == 0) return pack_result(cur, hops, ST_NO_FREE);
							links[cur] = fr[LINK_W-1:0];
							links[fr]  = EOC_VALUE;
							nxt = fr;
						end
						cur = nxt;
						hops++;
					end
					return pack_result(cur, hops, ST_OK);
				end
				MODE_APPEND: begin
					if (cur != 0 && cur >= lim) return pack_result(0, 0, ST_BAD_INDEX);
					fr = first_free();
					if (fr == 0) return pack_result(0, 0, ST_NO_FREE);
					if (cur != 0) links[cur] = fr[LINK_W-1:0];
					links[fr] = EOC_VALUE;
					return pack_result(fr, 1, ST_OK);
				end
				MODE_FREE: begin
					// a freed entry reads back as zero, so loops end here too
					for (int unsigned i = 0; i <= TABLE_DEPTH_DEF; i++) begin
						if (cur == 0 || cur >= eoc_mark) break;
						if (cur >= lim)
							return pack_result(cur, hops, (hops == 0) ? ST_BAD_INDEX : ST_WALK_LIMIT);
						nxt = links[cur];
						links[cur] = '0;
						hops++;
						cur = nxt;
					end
					return pack_result(cur, hops, ST_OK);
				end
				default: return pack_result(0, 0, ST_OK);
			endcase
		endfunction

		// Note an accepted request: predict its result and queue it.
		function rsp_t take_request(req_t r);
			rsp_t want;
			want = run_operation(r);
			awaited_q.push_back(want);
			return want;
		endfunction

		function void match_result(rsp_t got);
			rsp_t want;
			if (awaited_q.size() == 0) begin
				$error("result beat with no request outstanding: %h", got);
				errors++;
				return;
			end
			want = awaited_q.pop_front();
			if (got.result_cluster !== want.result_cluster) begin
				$error("result_cluster: expected %0d, actual %0d",
					want.result_cluster, got.result_cluster);
				errors++;
			end
			if (got.links_done !== want.links_done) begin
				$error("links_done: expected %0d, actual %0d", want.links_done, got.links_done);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	req_t                  req       = '0;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	link_table_tracker sb;
	int unsigned       recent_q[$];
	logic              steady = 1'b0;
	int                quiet_cycles = 0;

	fat_cluster_chain_manager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// check every result beat as it is shown
	always @(posedge clk) begin
		if (arst_n && done) sb.match_result(rsp);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((arst_n && start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("fat_cluster_chain_manager_tb: FAIL");
			$finish;
		end
	end

	function automatic req_t req_of(logic [MODE_W-1:0] m, int unsigned cl, int unsigned val,
		int unsigned n);
		req_t r;
		r.mode    = m;
		r.cluster = cl[LINK_W-1:0];
		r.value   = val[LINK_W-1:0];
		r.steps   = n[STEPS_W-1:0];
		return r;
	endfunction

	// Hold the beat until it is taken; drop start on random idle cycles.
	task automatic issue_request(input req_t r);
		logic taken;
		rsp_t want;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 99) < 28) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				req   <= r;
			end
			@(posedge clk);
			if (start && !busy) begin
				taken = 1'b1;
				want = sb.take_request(r);
				// keep recent clusters as likely chain heads and tails
				if (want.status == ST_OK && want.result_cluster != 0) begin
					recent_q.push_back(want.result_cluster);
					if (recent_q.size() > 16) void'(recent_q.pop_front());
				end
			end
		end
	endtask

	// Wait for every owed result, then let the block settle.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.awaited_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic retune(input int unsigned count, input int unsigned mark);
		drain();
		write_reg(CFG_CLUSTER_COUNT, CFG_DATA_W'(count));
		write_reg(CFG_END_MARKER, CFG_DATA_W'(mark));
	endtask

	// Mostly chain-shaped traffic: clusters drawn from recent results and the
	// live index range, links pointing inside the table, short walks.
	function automatic req_t random_request();
		req_t        r;
		int unsigned lim, roll, cl, val, n;
		lim  = sb.index_limit();
		roll = $urandom_range(0, 99);
		if (roll < 18)      r.mode = MODE_WRITE;
		else if (roll < 27) r.mode = MODE_READ;
		else if (roll < 46) r.mode = MODE_SEEK;
		else if (roll < 61) r.mode = MODE_SEEK_EXT;
		else if (roll < 82) r.mode = MODE_APPEND;
		else if (roll < 97) r.mode = MODE_FREE;
		else if (roll < 99) r.mode = MODE_SPARE_LO;
		else                r.mode = MODE_SPARE_HI;

		roll = $urandom_range(0, 99);
		if (roll < 45 && recent_q.size() != 0) cl = recent_q[$urandom_range(0, recent_q.size() - 1)];
		else if (roll < 80) cl = $urandom_range(0, lim - 1);
		else if (roll < 90) cl = $urandom_range(lim, lim + 4);
		else if (roll < 95) cl = 0;
		else                cl = $urandom_range(0, 28'h0FFFFFFF);

		roll = $urandom_range(0, 99);
		if (roll < 50)      val = $urandom_range(0, lim - 1);
		else if (roll < 65) val = $urandom_range(sb.eoc_mark, 28'h0FFFFFFF);
		else if (roll < 75) val = 0;
		else if (roll < 85) val = $urandom_range(lim, lim + 8);
		else                val = $urandom_range(0, 28'h0FFFFFFF);

		roll = $urandom_range(0, 99);
		if (roll < 70)      n = $urandom_range(0, 6);
		else if (roll < 85) n = $urandom_range(7, 40);
		else if (roll < 95) n = $urandom_range(0, 1024);
		else                n = 1024;
		// every allocation costs a table scan: keep long extends to small tables
		if (r.mode == MODE_SEEK_EXT && lim > 64 && n > 12) n = $urandom_range(0, 12);

		r.cluster = cl[LINK_W-1:0];
		r.value   = val[LINK_W-1:0];
		r.steps   = n[STEPS_W-1:0];
		return r;
	endfunction

	task automatic random_items(input int quota, input int calm);
		req_t r;
		int   n;
		n = 0;
		while (n < quota) begin
			steady = (n < calm);
			r = random_request();
			issue_request(r);
			if (r.mode <= MODE_FREE) n++;
		end
		steady = 1'b0;
	endtask

	// Edges of the fields, each operation and each corner of the walks.
	task automatic directed_items();
		issue_request(req_of(MODE_READ,     0,            0,            0));
		issue_request(req_of(MODE_WRITE,    1023,         28'h0FFFFFFF, 0));
		issue_request(req_of(MODE_READ,     1023,         0,            0));
		issue_request(req_of(MODE_WRITE,    1024,         5,            0));
		issue_request(req_of(MODE_READ,     28'h0FFFFFFF, 0,            2047));
		issue_request(req_of(MODE_APPEND,   0,            0,            0));
		issue_request(req_of(MODE_APPEND,   2,            0,            0));
		issue_request(req_of(MODE_APPEND,   3,            0,            0));
		issue_request(req_of(MODE_APPEND,   28'h0FFFFFFF, 0,            0));
		issue_request(req_of(MODE_SEEK,     2,            0,            0));
		issue_request(req_of(MODE_SEEK,     2,            0,            1));
		issue_request(req_of(MODE_SEEK,     2,            0,            1024));
		issue_request(req_of(MODE_SEEK,     1024,         0,            0));
		issue_request(req_of(MODE_SEEK,     28'h0FFFFFF9, 0,            0));
		issue_request(req_of(MODE_SEEK,     1500,         0,            3));
		issue_request(req_of(MODE_WRITE,    5,            2000,         0));
		issue_request(req_of(MODE_SEEK,     5,            0,            2));
		issue_request(req_of(MODE_SEEK_EXT, 0,            0,            0));
		issue_request(req_of(MODE_SEEK_EXT, 2,            0,            5));
		issue_request(req_of(MODE_FREE,     2,            0,            0));
		issue_request(req_of(MODE_FREE,     0,            0,            0));
		issue_request(req_of(MODE_FREE,     1024,         0,            0));
		issue_request(req_of(MODE_FREE,     5,            0,            0));
		issue_request(req_of(MODE_WRITE,    6,            6,            0));
		issue_request(req_of(MODE_FREE,     6,            0,            0));
		issue_request(req_of(MODE_SPARE_LO, 7,            7,            7));
		issue_request(req_of(MODE_SPARE_HI, 28'h0FFFFFFF, 28'h0FFFFFFF, 2047));
	endtask

	initial begin
		sb = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		directed_items();
		random_items(60, 0);
		retune(3, END_MARKER_RST);
		random_items(50, 0);
		retune(40, 28'h0FFFFFFF);
		random_items(150, 75);
		retune(260, 150);
		random_items(140, 0);
		retune(16, 2);
		random_items(70, 0);
		retune(1024, END_MARKER_RST);
		random_items(40, 0);
		retune(1023, 300);
		random_items(70, 0);
		drain();
		repeat (20) @(posedge clk);

		if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
			$display("fat_cluster_chain_manager_tb: PASS");
		end else begin
			$display("fat_cluster_chain_manager_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: fat_cluster_chain_manager.f
rtl/core/fccm_pkg.sv
rtl/core/fccm_datapath.sv
rtl/core/fccm_ctrl.sv
rtl/core/fat_cluster_chain_manager.sv
rtl/core/fccm_checker.sv
test/fat_cluster_chain_manager_tb.sv
